// ----- rtl/core/i2c_master_transfer_sequencer_assert.svh -----
// assertion macros for the i2c master transfer sequencer checker
// expects clk_i and rst_ni in the scope of each use
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define I2CMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2cms: same-cycle check failed");

// next-cycle implication
`define I2CMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cms: next-cycle check failed");

`endif

// ----- rtl/core/i2cms_pkg.sv -----
// types and constants of the i2c master transfer sequencer
// no dependencies
`default_nettype none

package i2cms_pkg;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_START = 2'd1,
    FN_EVENT = 2'd2,
    FN_STOP  = 2'd3
  } func_e;

  typedef enum logic [4:0] {
    ST_BUS_ERR     = 5'h00,
    ST_START       = 5'h01,
    ST_RSTART      = 5'h02,
    ST_SLA_W_ACK   = 5'h03,
    ST_SLA_W_NACK  = 5'h04,
    ST_DATA_W_ACK  = 5'h05,
    ST_DATA_W_NACK = 5'h06,
    ST_ARB_LOST    = 5'h07,
    ST_SLA_R_ACK   = 5'h08,
    ST_SLA_R_NACK  = 5'h09,
    ST_DATA_R_ACK  = 5'h0A,
    ST_DATA_R_NACK = 5'h0B
  } status_e;

  typedef enum logic [1:0] {
    OUT_BUSY = 2'd0,
    OUT_OK   = 2'd1,
    OUT_FAIL = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    REG_TARGET_ADDR = 3'd0,
    REG_START_READ  = 3'd1,
    REG_ACK_POLL    = 3'd2,
    REG_RAND_READ   = 3'd3,
    REG_CHAIN       = 3'd4,
    REG_FIRST_LEN   = 3'd5,
    REG_SECOND_LEN  = 3'd6
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;

  // controller control register bits
  localparam logic [5:0] CTRL_AA  = 6'h04;
  localparam logic [5:0] CTRL_SI  = 6'h08;
  localparam logic [5:0] CTRL_STO = 6'h10;
  localparam logic [5:0] CTRL_STA = 6'h20;

  typedef struct packed {
    logic [1:0] func;
    logic [4:0] status_code;
    logic [7:0] received_byte;
    logic       load_which;
    logic [3:0] load_index;
    logic [7:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0] ctrl_set;
    logic [5:0] ctrl_clear;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       got_valid;
    logic       got_which;
    logic [3:0] got_index;
    logic [7:0] got_byte;
    logic [1:0] outcome;
  } out_item_t;

  typedef struct packed {
    logic [6:0] target_addr;
    logic       start_read;
    logic       ack_polling;
    logic       random_read;
    logic       chain_second;
    logic [4:0] first_length;
    logic [4:0] second_length;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/i2cms_seq.sv -----
// transfer state, status code decode and the byte store memory
// depends on i2cms_pkg
`default_nettype none

module i2cms_seq #(
  parameter int unsigned BUF_DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire i2cms_pkg::in_item_t  item_i,
  input  wire i2cms_pkg::cfg_t      cfg_i,
  output i2cms_pkg::out_item_t      res_o,
  output logic                      send_mem_o,
  output logic [7:0]                rd_data_o
);

  localparam int unsigned IdxW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned CurW = $clog2(BUF_DEPTH + 1);

  logic            cursor_which_q, cursor_which_d;
  logic [CurW-1:0] cursor_q, cursor_d;
  logic [4:0]      remaining_q, remaining_d;
  logic            direction_q, direction_d;
  logic            chain_q, chain_d;
  i2cms_pkg::outcome_e result_q, result_d;

  logic [7:0] mem_q [2**(IdxW+1)];
  logic [7:0] rd_data_q;

  logic            wr_en;
  logic            wr_which;
  logic [IdxW-1:0] wr_idx;
  logic [7:0]      wr_data;
  logic            rd_en;
  logic            rd_which;
  logic [IdxW-1:0] rd_idx;

  logic [31:0]     cur_ext;
  logic [31:0]     li_ext;
  logic            cur_in;
  logic            li_ok;
  logic [4:0]      rem_dec;

  assign cur_ext = 32'(cursor_q);
  assign li_ext  = 32'(item_i.load_index);
  assign cur_in  = cursor_q < CurW'(BUF_DEPTH);
  assign li_ok   = li_ext < 32'(BUF_DEPTH);
  assign rem_dec = (remaining_q != 5'd0) ? remaining_q - 5'd1 : 5'd0;

  always_comb begin
    cursor_which_d = cursor_which_q;
    cursor_d       = cursor_q;
    remaining_d    = remaining_q;
    direction_d    = direction_q;
    chain_d        = chain_q;
    result_d       = result_q;
    res_o          = '0;
    send_mem_o     = 1'b0;
    wr_en          = 1'b0;
    wr_which       = cursor_which_q;
    wr_idx         = cursor_q[IdxW-1:0];
    wr_data        = item_i.received_byte;
    rd_en          = 1'b0;
    rd_which       = cursor_which_q;
    rd_idx         = cursor_q[IdxW-1:0];

    unique case (i2cms_pkg::func_e'(item_i.func))
      i2cms_pkg::FN_LOAD: begin
        wr_en    = li_ok;
        wr_which = item_i.load_which;
        wr_idx   = li_ext[IdxW-1:0];
        wr_data  = item_i.load_value;
      end
      i2cms_pkg::FN_START: begin
        result_d       = i2cms_pkg::OUT_BUSY;
        direction_d    = cfg_i.start_read;
        chain_d        = cfg_i.chain_second;
        res_o.ctrl_set = i2cms_pkg::CTRL_STA;
      end
      i2cms_pkg::FN_STOP: begin
        res_o.ctrl_set   = i2cms_pkg::CTRL_STO | i2cms_pkg::CTRL_AA;
        res_o.ctrl_clear = i2cms_pkg::CTRL_SI;
      end
      i2cms_pkg::FN_EVENT: begin
        case (i2cms_pkg::status_e'(item_i.status_code)) inside
          i2cms_pkg::ST_BUS_ERR, i2cms_pkg::ST_DATA_W_NACK,
          i2cms_pkg::ST_SLA_R_NACK: begin
            res_o.ctrl_set   = i2cms_pkg::CTRL_STO | i2cms_pkg::CTRL_AA;
            res_o.ctrl_clear = i2cms_pkg::CTRL_SI;
            result_d         = i2cms_pkg::OUT_FAIL;
          end
          i2cms_pkg::ST_START, i2cms_pkg::ST_RSTART: begin
            res_o.send_valid = 1'b1;
            res_o.send_byte  = {cfg_i.target_addr, direction_q};
            res_o.ctrl_set   = i2cms_pkg::CTRL_AA;
            res_o.ctrl_clear = i2cms_pkg::CTRL_STA | i2cms_pkg::CTRL_SI;
            cursor_d         = '0;
            if (item_i.status_code == i2cms_pkg::ST_RSTART) begin
              remaining_d    = cfg_i.second_length;
              cursor_which_d = 1'b1;
            end else begin
              remaining_d    = cfg_i.first_length;
              cursor_which_d = 1'b0;
            end
          end
          i2cms_pkg::ST_SLA_W_ACK: begin
            res_o.ctrl_clear = i2cms_pkg::CTRL_SI;
            if (cfg_i.ack_polling) begin
              res_o.ctrl_set = i2cms_pkg::CTRL_STO | i2cms_pkg::CTRL_AA;
              result_d       = i2cms_pkg::OUT_OK;
            end else begin
              res_o.ctrl_set   = i2cms_pkg::CTRL_AA;
              res_o.send_valid = 1'b1;
              rd_en            = cur_in;
              send_mem_o       = cur_in;
              if (cur_in) begin
                cursor_d = cursor_q + CurW'(1);
              end
            end
          end
          i2cms_pkg::ST_SLA_W_NACK: begin
            res_o.ctrl_clear = i2cms_pkg::CTRL_SI;
            if (cfg_i.ack_polling) begin
              res_o.ctrl_set = i2cms_pkg::CTRL_STA | i2cms_pkg::CTRL_AA;
            end else begin
              res_o.ctrl_set = i2cms_pkg::CTRL_STO | i2cms_pkg::CTRL_AA;
              result_d       = i2cms_pkg::OUT_FAIL;
            end
          end
          i2cms_pkg::ST_DATA_W_ACK: begin
            res_o.ctrl_clear = i2cms_pkg::CTRL_SI;
            remaining_d      = rem_dec;
            if (rem_dec != 5'd0) begin
              res_o.ctrl_set   = i2cms_pkg::CTRL_AA;
              res_o.send_valid = 1'b1;
              rd_en            = cur_in;
              send_mem_o       = cur_in;
              if (cur_in) begin
                cursor_d = cursor_q + CurW'(1);
              end
            end else if (cfg_i.random_read) begin
              direction_d    = 1'b1;
              res_o.ctrl_set = i2cms_pkg::CTRL_STA | i2cms_pkg::CTRL_AA;
            end else if (chain_q) begin
              // move on to the second store from its first byte
              cursor_which_d   = 1'b1;
              cursor_d         = CurW'(1);
              remaining_d      = cfg_i.second_length;
              chain_d          = 1'b0;
              res_o.ctrl_set   = i2cms_pkg::CTRL_AA;
              res_o.send_valid = 1'b1;
              rd_en            = 1'b1;
              send_mem_o       = 1'b1;
              rd_which         = 1'b1;
              rd_idx           = '0;
            end else begin
              res_o.ctrl_set = i2cms_pkg::CTRL_STO | i2cms_pkg::CTRL_AA;
              result_d       = i2cms_pkg::OUT_OK;
            end
          end
          i2cms_pkg::ST_ARB_LOST: begin
            res_o.ctrl_set   = i2cms_pkg::CTRL_STA | i2cms_pkg::CTRL_AA;
            res_o.ctrl_clear = i2cms_pkg::CTRL_SI;
          end
          i2cms_pkg::ST_SLA_R_ACK: begin
            if (remaining_q == 5'd1) begin
              res_o.ctrl_clear = i2cms_pkg::CTRL_AA | i2cms_pkg::CTRL_SI;
            end else begin
              res_o.ctrl_set   = i2cms_pkg::CTRL_AA;
              res_o.ctrl_clear = i2cms_pkg::CTRL_SI;
            end
          end
          i2cms_pkg::ST_DATA_R_ACK: begin
            wr_en           = cur_in;
            res_o.got_valid = cur_in;
            res_o.got_which = cur_in & cursor_which_q;
            res_o.got_index = cur_in ? cur_ext[3:0] : 4'd0;
            res_o.got_byte  = cur_in ? item_i.received_byte : 8'd0;
            remaining_d     = rem_dec;
            if (rem_dec == 5'd1) begin
              res_o.ctrl_clear = i2cms_pkg::CTRL_AA | i2cms_pkg::CTRL_SI;
            end else begin
              res_o.ctrl_set   = i2cms_pkg::CTRL_AA;
              res_o.ctrl_clear = i2cms_pkg::CTRL_SI;
            end
            if (cur_in) begin
              cursor_d = cursor_q + CurW'(1);
            end
          end
          i2cms_pkg::ST_DATA_R_NACK: begin
            wr_en            = cur_in;
            res_o.got_valid  = cur_in;
            res_o.got_which  = cur_in & cursor_which_q;
            res_o.got_index  = cur_in ? cur_ext[3:0] : 4'd0;
            res_o.got_byte   = cur_in ? item_i.received_byte : 8'd0;
            res_o.ctrl_set   = i2cms_pkg::CTRL_STO | i2cms_pkg::CTRL_AA;
            res_o.ctrl_clear = i2cms_pkg::CTRL_SI;
            result_d         = i2cms_pkg::OUT_OK;
          end
          default: begin
          end
        endcase
      end
    endcase

    res_o.outcome = result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_which_q <= 1'b0;
      cursor_q       <= '0;
      remaining_q    <= 5'd0;
      direction_q    <= 1'b0;
      chain_q        <= 1'b0;
      result_q       <= i2cms_pkg::OUT_BUSY;
    end else if (accept_i) begin
      cursor_which_q <= cursor_which_d;
      cursor_q       <= cursor_d;
      remaining_q    <= remaining_d;
      direction_q    <= direction_d;
      chain_q        <= chain_d;
      result_q       <= result_d;
    end
  end

  // both stores in one memory, store select on the top address bit
  always_ff @(posedge clk_i) begin
    if (accept_i && wr_en) begin
      mem_q[{wr_which, wr_idx}] <= wr_data;
    end
    if (accept_i && rd_en) begin
      rd_data_q <= mem_q[{rd_which, rd_idx}];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/i2c_master_transfer_sequencer.sv -----
// top level of the i2c master transfer sequencer: handshake, config, result register
// depends on i2cms_pkg and i2cms_seq
//
//  channel   dir   handshake                 payload
//  in        in    in_valid_i / in_ready_o   in_data_i   (i2cms_pkg::in_item_t)
//  out       out   out_valid_o / out_ready_i out_data_o  (i2cms_pkg::out_item_t)
//  cfg       in    cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one request per cycle unless out is stalled; its result is registered and shows in the cycle after acceptance
// the transmit byte comes from the single registered read port of the byte store memory
// a new request is taken whenever the result register is empty or being drained
// reset clears transfer state and sets config to its defaults; store contents are left as they are
`default_nettype none

module i2c_master_transfer_sequencer #(
  parameter int unsigned BUF_DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire i2cms_pkg::in_item_t            in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output i2cms_pkg::out_item_t                out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [i2cms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [i2cms_pkg::CfgDataW-1:0] cfg_wdata_i
);

  i2cms_pkg::cfg_t      cfg_q;
  i2cms_pkg::out_item_t res_d, res_q;
  logic                 send_mem_d, send_mem_q;
  logic                 valid_q;
  logic                 accept;
  logic [7:0]           rd_data;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_addr   <= 7'd0;
      cfg_q.start_read    <= 1'b0;
      cfg_q.ack_polling   <= 1'b0;
      cfg_q.random_read   <= 1'b0;
      cfg_q.chain_second  <= 1'b0;
      cfg_q.first_length  <= 5'd1;
      cfg_q.second_length <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        i2cms_pkg::REG_TARGET_ADDR: cfg_q.target_addr   <= cfg_wdata_i;
        i2cms_pkg::REG_START_READ:  cfg_q.start_read    <= cfg_wdata_i[0];
        i2cms_pkg::REG_ACK_POLL:    cfg_q.ack_polling   <= cfg_wdata_i[0];
        i2cms_pkg::REG_RAND_READ:   cfg_q.random_read   <= cfg_wdata_i[0];
        i2cms_pkg::REG_CHAIN:       cfg_q.chain_second  <= cfg_wdata_i[0];
        i2cms_pkg::REG_FIRST_LEN:   cfg_q.first_length  <= cfg_wdata_i[4:0];
        i2cms_pkg::REG_SECOND_LEN:  cfg_q.second_length <= cfg_wdata_i[4:0];
        default: begin
        end
      endcase
    end
  end

  i2cms_seq #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .cfg_i      (cfg_q),
    .res_o      (res_d),
    .send_mem_o (send_mem_d),
    .rd_data_o  (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q      <= res_d;
      send_mem_q <= send_mem_d;
    end
  end

  always_comb begin
    out_data_o = res_q;
    if (send_mem_q) begin
      out_data_o.send_byte = rd_data;
    end
  end

  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/i2cms_checker.sv -----
// port-level checks on the i2c master transfer sequencer, bound to the top level
// depends on i2cms_pkg and i2c_master_transfer_sequencer_assert.svh
`default_nettype none

`include "i2c_master_transfer_sequencer_assert.svh"

module i2cms_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire i2cms_pkg::out_item_t           out_data_o
);

  logic stalled;
  logic in_take;
  logic got_zero;

  assign stalled  = out_valid_o && !out_ready_i;
  assign in_take  = in_valid_i && in_ready_o;
  assign got_zero = out_data_o.got_index == 4'd0 && out_data_o.got_byte == 8'd0;

  `I2CMS_ASSERT_NEXT(a_out_hold, stalled, out_valid_o && $stable(out_data_o))
  `I2CMS_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o)
  `I2CMS_ASSERT_NEXT(a_result_follows, in_take, out_valid_o)
  `I2CMS_ASSERT_NOW(a_got_zero, out_valid_o && !out_data_o.got_valid, got_zero)
  `I2CMS_ASSERT_NOW(a_outcome_code, out_valid_o, out_data_o.outcome != 2'd3)

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_i2cms_checker (.*);

`default_nettype wire

// ----- verif/tb_i2c_master_transfer_sequencer.sv -----
// self-checking testbench for i2c_master_transfer_sequencer: buffer fill, directed table, then
// random transfers under changing register settings, each result checked in request order
// depends on i2cms_pkg and the rtl of the sequencer
`default_nettype none

module tb_i2c_master_transfer_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cms_pkg::*;

  localparam int BUF_DEPTH = 16;
  localparam int ITEM_TARGET = 1950;
  localparam int PRINT_CAP = 200;
  localparam logic [4:0] UNKNOWN_LOW = 5'h0C;
  localparam logic [4:0] UNKNOWN_TOP = 5'h1F;

  typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_PERIODIC, DRAIN_SPARSE} drain_mode_e;

  typedef struct {
    in_item_t  req;
    logic      fixed;
    out_item_t want;
  } table_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_item_t in_data = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  logic req_fixed = 1'b0;
  out_item_t req_fixed_result = '0;

  // shadow of the sequencer state
  cfg_t regs = '{7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 5'd1, 5'd1};
  logic [7:0] first_bytes [BUF_DEPTH];
  logic [7:0] second_bytes [BUF_DEPTH];
  logic cur_sel = 1'b0;
  logic [4:0] cur_pos = '0;
  logic [4:0] bytes_left = '0;
  logic dir_rd = 1'b0;
  logic chain_armed = 1'b0;
  outcome_e xfer_outcome = OUT_BUSY;

  out_item_t expected_results[$];
  in_item_t planned[$];
  table_row_t directed_rows[$];
  int error_count = 0;
  int request_count = 0;
  int burst_left = 0;
  drain_mode_e stall_mode = DRAIN_FREE;
  int stall_span = 0;

  i2c_master_transfer_sequencer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void transmit_next(inout out_item_t res);
    res.send_valid = 1'b1;
    res.send_byte = '0;
    if (cur_pos < BUF_DEPTH) begin
      res.send_byte = cur_sel ? second_bytes[cur_pos[3:0]] : first_bytes[cur_pos[3:0]];
      cur_pos++;
    end
  endfunction

  function automatic void take_received(inout out_item_t res, input logic [7:0] rx);
    if (cur_pos < BUF_DEPTH) begin
      if (cur_sel) second_bytes[cur_pos[3:0]] = rx;
      else first_bytes[cur_pos[3:0]] = rx;
      res.got_valid = 1'b1;
      res.got_which = cur_sel;
      res.got_index = cur_pos[3:0];
      res.got_byte = rx;
    end
  endfunction

  function automatic void address_out(inout out_item_t res);
    res.send_valid = 1'b1;
    res.send_byte = {regs.target_addr, dir_rd};
  endfunction

  function automatic void count_down();
    if (bytes_left != 0) bytes_left--;
  endfunction

  function automatic out_item_t predict_result(input in_item_t r);
    out_item_t res;
    res = '0;
    case (r.func)
      FN_LOAD: begin
        if (r.load_which) second_bytes[r.load_index] = r.load_value;
        else first_bytes[r.load_index] = r.load_value;
      end
      FN_START: begin
        xfer_outcome = OUT_BUSY;
        dir_rd = regs.start_read;
        chain_armed = regs.chain_second;
        res.ctrl_set = CTRL_STA;
      end
      FN_EVENT: begin
        case (r.status_code) inside
          ST_BUS_ERR, ST_DATA_W_NACK, ST_SLA_R_NACK: begin
            res.ctrl_set = CTRL_STO | CTRL_AA;
            res.ctrl_clear = CTRL_SI;
            xfer_outcome = OUT_FAIL;
          end
          ST_START, ST_RSTART: begin
            address_out(res);
            res.ctrl_set = CTRL_AA;
            res.ctrl_clear = CTRL_STA | CTRL_SI;
            cur_sel = (r.status_code == ST_RSTART);
            bytes_left = cur_sel ? regs.second_length : regs.first_length;
            cur_pos = '0;
          end
          ST_SLA_W_ACK: begin
            if (regs.ack_polling) begin
              res.ctrl_set = CTRL_STO | CTRL_AA;
              xfer_outcome = OUT_OK;
            end else begin
              transmit_next(res);
              res.ctrl_set = CTRL_AA;
            end
            res.ctrl_clear = CTRL_SI;
          end
          ST_SLA_W_NACK: begin
            if (regs.ack_polling) begin
              res.ctrl_set = CTRL_STA | CTRL_AA;
            end else begin
              res.ctrl_set = CTRL_STO | CTRL_AA;
              xfer_outcome = OUT_FAIL;
            end
            res.ctrl_clear = CTRL_SI;
          end
          ST_DATA_W_ACK: begin
            count_down();
            if (bytes_left != 0) begin
              transmit_next(res);
              res.ctrl_set = CTRL_AA;
            end else if (regs.random_read) begin
              dir_rd = 1'b1;
              res.ctrl_set = CTRL_STA | CTRL_AA;
            end else if (chain_armed) begin
              cur_sel = 1'b1;
              cur_pos = '0;
              bytes_left = regs.second_length;
              chain_armed = 1'b0;
              transmit_next(res);
              res.ctrl_set = CTRL_AA;
            end else begin
              res.ctrl_set = CTRL_STO | CTRL_AA;
              xfer_outcome = OUT_OK;
            end
            res.ctrl_clear = CTRL_SI;
          end
          ST_ARB_LOST: begin
            res.ctrl_set = CTRL_STA | CTRL_AA;
            res.ctrl_clear = CTRL_SI;
          end
          ST_SLA_R_ACK, ST_DATA_R_ACK: begin
            if (r.status_code == ST_DATA_R_ACK) begin
              take_received(res, r.received_byte);
              count_down();
            end
            if (bytes_left == 1) begin
              res.ctrl_clear = CTRL_SI | CTRL_AA;
            end else begin
              res.ctrl_set = CTRL_AA;
              res.ctrl_clear = CTRL_SI;
            end
            if (r.status_code == ST_DATA_R_ACK && cur_pos < BUF_DEPTH) cur_pos++;
          end
          ST_DATA_R_NACK: begin
            take_received(res, r.received_byte);
            res.ctrl_set = CTRL_STO | CTRL_AA;
            res.ctrl_clear = CTRL_SI;
            xfer_outcome = OUT_OK;
          end
          default: ;
        endcase
      end
      default: begin
        res.ctrl_set = CTRL_STO | CTRL_AA;
        res.ctrl_clear = CTRL_SI;
      end
    endcase
    res.outcome = xfer_outcome;
    return res;
  endfunction

  function automatic in_item_t any_request();
    return in_item_t'(($bits(in_item_t))'($urandom));
  endfunction

  function automatic in_item_t cmd_req(input func_e f);
    in_item_t r;
    r = any_request();
    r.func = f;
    return r;
  endfunction

  function automatic in_item_t event_req(input logic [4:0] code, input logic [7:0] rx);
    in_item_t r;
    r = cmd_req(FN_EVENT);
    r.status_code = code;
    r.received_byte = rx;
    return r;
  endfunction

  function automatic in_item_t load_req(input logic which, input logic [3:0] idx,
                                        input logic [7:0] val);
    in_item_t r;
    r = cmd_req(FN_LOAD);
    r.load_which = which;
    r.load_index = idx;
    r.load_value = val;
    return r;
  endfunction

  function automatic out_item_t reply(input logic [5:0] set, input logic [5:0] clr,
                                      input logic sv, input logic [7:0] sb,
                                      input outcome_e oc);
    out_item_t res;
    res = '0;
    res.ctrl_set = set;
    res.ctrl_clear = clr;
    res.send_valid = sv;
    res.send_byte = sb;
    res.outcome = oc;
    return res;
  endfunction

  task automatic add_row(input in_item_t req, input logic fixed, input out_item_t want);
    table_row_t row;
    row.req = req;
    row.fixed = fixed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      if (error_count < PRINT_CAP)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && in_valid && in_ready) begin
      want = predict_result(in_data);
      if (req_fixed) want = req_fixed_result;
      expected_results.push_back(want);
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (error_count < PRINT_CAP)
          $display("%0t ns: result with no request outstanding, got %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("ctrl_set", want.ctrl_set, out_data.ctrl_set);
        check_field("ctrl_clear", want.ctrl_clear, out_data.ctrl_clear);
        check_field("send_valid", want.send_valid, out_data.send_valid);
        check_field("send_byte", want.send_byte, out_data.send_byte);
        check_field("got_valid", want.got_valid, out_data.got_valid);
        check_field("got_which", want.got_which, out_data.got_which);
        check_field("got_index", want.got_index, out_data.got_index);
        check_field("got_byte", want.got_byte, out_data.got_byte);
        check_field("outcome", want.outcome, out_data.outcome);
      end
    end
  end

  // receiver back-pressure, changing its pattern every so often
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = drain_mode_e'($urandom_range(0, 3));
      stall_span = $urandom_range(16, 160);
    end
    stall_span--;
    case (stall_mode)
      DRAIN_FREE:     out_ready <= 1'b1;
      DRAIN_COIN:     out_ready <= 1'($urandom_range(0, 1));
      DRAIN_PERIODIC: out_ready <= (stall_span % 3 == 0);
      default:        out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_request(input in_item_t req, input logic fixed, input out_item_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= req;
    req_fixed <= fixed;
    req_fixed_result <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0 || out_valid) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_registers(input cfg_t c);
    cfg_reg_e idx;
    regs = c;
    idx = idx.first();
    do begin
      cfg_we <= 1'b1;
      cfg_idx <= idx;
      case (idx)
        REG_TARGET_ADDR: cfg_wdata <= c.target_addr;
        REG_START_READ:  cfg_wdata <= 7'(c.start_read);
        REG_ACK_POLL:    cfg_wdata <= 7'(c.ack_polling);
        REG_RAND_READ:   cfg_wdata <= 7'(c.random_read);
        REG_CHAIN:       cfg_wdata <= 7'(c.chain_second);
        REG_FIRST_LEN:   cfg_wdata <= 7'(c.first_length);
        default:         cfg_wdata <= 7'(c.second_length);
      endcase
      @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t choose_settings(input int phase);
    cfg_t c;
    c.target_addr = 7'($urandom_range(0, 127));
    c.start_read = 1'($urandom_range(0, 1));
    c.ack_polling = ($urandom_range(0, 3) == 0);
    c.random_read = ($urandom_range(0, 2) == 0);
    c.chain_second = 1'($urandom_range(0, 1));
    c.first_length = 5'($urandom_range(1, 16));
    c.second_length = 5'($urandom_range(1, 16));
    case (phase % 4)
      0: begin
        c.target_addr = (phase % 8 == 0) ? 7'h00 : 7'h7F;
        c.first_length = 5'd1;
        c.second_length = 5'd16;
      end
      1: begin
        c.first_length = 5'd16;
        c.second_length = 5'd1;
      end
      2: begin
        // lengths outside the usual range
        c.first_length = $urandom_range(0, 1) ? 5'd0 : 5'd31;
        c.second_length = $urandom_range(0, 1) ? 5'd0 : 5'd31;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic plan_transfer();
    int n1;
    int n2;
    int cut;
    n1 = (regs.first_length == 0) ? 1 : int'(regs.first_length);
    n2 = (regs.second_length == 0) ? 1 : int'(regs.second_length);
    planned.push_back(cmd_req(FN_START));
    planned.push_back(event_req(ST_START, 8'($urandom)));
    if (regs.ack_polling) begin
      repeat ($urandom_range(0, 3)) begin
        planned.push_back(event_req(ST_SLA_W_NACK, 8'($urandom)));
        planned.push_back(event_req(ST_START, 8'($urandom)));
      end
      planned.push_back(event_req(ST_SLA_W_ACK, 8'($urandom)));
    end else if (regs.start_read && !regs.random_read) begin
      planned.push_back(event_req(ST_SLA_R_ACK, 8'($urandom)));
      repeat (n1 - 1) planned.push_back(event_req(ST_DATA_R_ACK, 8'($urandom)));
      planned.push_back(event_req(ST_DATA_R_NACK, 8'($urandom)));
    end else begin
      planned.push_back(event_req(ST_SLA_W_ACK, 8'($urandom)));
      repeat (n1) planned.push_back(event_req(ST_DATA_W_ACK, 8'($urandom)));
      if (regs.random_read) begin
        planned.push_back(event_req(ST_RSTART, 8'($urandom)));
        planned.push_back(event_req(ST_SLA_R_ACK, 8'($urandom)));
        repeat (n2 - 1) planned.push_back(event_req(ST_DATA_R_ACK, 8'($urandom)));
        planned.push_back(event_req(ST_DATA_R_NACK, 8'($urandom)));
      end else if (regs.chain_second) begin
        repeat (n2) planned.push_back(event_req(ST_DATA_W_ACK, 8'($urandom)));
      end
    end
    // broken transfer: cut short by an arbitrary status
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, planned.size() - 1);
      while (planned.size() > cut) void'(planned.pop_back());
      planned.push_back(event_req(5'($urandom_range(0, 31)), 8'($urandom)));
    end
    planned.push_back(cmd_req(FN_STOP));
  endtask

  initial begin
    #5ms;
    $display("** i2c_master_transfer_sequencer: FAILED **");
    $finish;
  end

  initial begin
    out_item_t rx_row;
    in_item_t req;
    int phase;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int w = 0; w < 2; w++)
      for (int k = 0; k < BUF_DEPTH; k++)
        send_request(load_req(1'(w), 4'(k), 8'($urandom)), 1'b0, '0);

    add_row(cmd_req(FN_STOP), 1'b1, reply(CTRL_STO | CTRL_AA, CTRL_SI, 1'b0, 8'h00, OUT_BUSY));
    add_row(event_req(ST_DATA_W_ACK, 8'h00), 1'b1,
            reply(CTRL_STO | CTRL_AA, CTRL_SI, 1'b0, 8'h00, OUT_OK));
    add_row(event_req(UNKNOWN_TOP, 8'hFF), 1'b1, reply('0, '0, 1'b0, 8'h00, OUT_OK));
    add_row(event_req(UNKNOWN_LOW, 8'h00), 1'b1, reply('0, '0, 1'b0, 8'h00, OUT_OK));
    add_row(load_req(1'b0, 4'd0, 8'hFF), 1'b1, reply('0, '0, 1'b0, 8'h00, OUT_OK));
    add_row(load_req(1'b1, 4'd15, 8'h00), 1'b1, reply('0, '0, 1'b0, 8'h00, OUT_OK));
    add_row(cmd_req(FN_START), 1'b1, reply(CTRL_STA, '0, 1'b0, 8'h00, OUT_BUSY));
    add_row(event_req(ST_START, 8'h00), 1'b1,
            reply(CTRL_AA, CTRL_STA | CTRL_SI, 1'b1, 8'h00, OUT_BUSY));
    add_row(event_req(ST_SLA_W_ACK, 8'h00), 1'b1,
            reply(CTRL_AA, CTRL_SI, 1'b1, 8'hFF, OUT_BUSY));
    add_row(event_req(ST_DATA_W_ACK, 8'h00), 1'b1,
            reply(CTRL_STO | CTRL_AA, CTRL_SI, 1'b0, 8'h00, OUT_OK));
    add_row(cmd_req(FN_STOP), 1'b1, reply(CTRL_STO | CTRL_AA, CTRL_SI, 1'b0, 8'h00, OUT_OK));
    add_row(cmd_req(FN_START), 1'b1, reply(CTRL_STA, '0, 1'b0, 8'h00, OUT_BUSY));
    add_row(event_req(ST_START, 8'hFF), 1'b1,
            reply(CTRL_AA, CTRL_STA | CTRL_SI, 1'b1, 8'h00, OUT_BUSY));
    add_row(event_req(ST_SLA_R_ACK, 8'h00), 1'b1,
            reply('0, CTRL_SI | CTRL_AA, 1'b0, 8'h00, OUT_BUSY));
    rx_row = reply(CTRL_STO | CTRL_AA, CTRL_SI, 1'b0, 8'h00, OUT_OK);
    rx_row.got_valid = 1'b1;
    rx_row.got_byte = 8'hA5;
    add_row(event_req(ST_DATA_R_NACK, 8'hA5), 1'b1, rx_row);
    add_row(event_req(ST_DATA_R_ACK, 8'h00), 1'b0, '0);
    add_row(event_req(ST_SLA_W_NACK, 8'h00), 1'b1,
            reply(CTRL_STO | CTRL_AA, CTRL_SI, 1'b0, 8'h00, OUT_FAIL));
    add_row(event_req(ST_BUS_ERR, 8'h00), 1'b1,
            reply(CTRL_STO | CTRL_AA, CTRL_SI, 1'b0, 8'h00, OUT_FAIL));
    add_row(event_req(ST_DATA_W_NACK, 8'h00), 1'b1,
            reply(CTRL_STO | CTRL_AA, CTRL_SI, 1'b0, 8'h00, OUT_FAIL));
    add_row(event_req(ST_SLA_R_NACK, 8'h00), 1'b1,
            reply(CTRL_STO | CTRL_AA, CTRL_SI, 1'b0, 8'h00, OUT_FAIL));
    add_row(event_req(ST_ARB_LOST, 8'h00), 1'b1,
            reply(CTRL_STA | CTRL_AA, CTRL_SI, 1'b0, 8'h00, OUT_FAIL));
    add_row(event_req(ST_RSTART, 8'h00), 1'b0, '0);
    add_row(event_req(ST_SLA_W_ACK, 8'h00), 1'b0, '0);
    add_row(load_req(1'b1, 4'd7, 8'h5A), 1'b0, '0);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);

    phase = 0;
    while (request_count < ITEM_TARGET) begin
      settle();
      program_registers(choose_settings(phase));
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 3) != 0) plan_transfer();
        else repeat ($urandom_range(1, 6)) planned.push_back(any_request());
        while (planned.size() != 0) begin
          req = planned.pop_front();
          send_request(req, 1'b0, '0);
          if (!(req.func == FN_EVENT && req.status_code > ST_DATA_R_NACK)) request_count++;
        end
      end
      phase++;
    end

    settle();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("** i2c_master_transfer_sequencer: PASSED **");
    end else begin
      $display("** i2c_master_transfer_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/i2cms_pkg.sv
rtl/core/i2cms_seq.sv
rtl/core/i2c_master_transfer_sequencer.sv
rtl/core/i2cms_checker.sv
verif/tb_i2c_master_transfer_sequencer.sv
